// File: sv/snorm_pkg.sv
// snorm_pkg: shared types, state encoding and exponent tables for softmax_normalizer
// depends on nothing; used by snorm_exp, snorm_div and softmax_normalizer
`default_nettype none

package snorm_pkg;

    localparam int unsigned EXP_W      = 16;
    localparam int unsigned QUOT_W     = 17;
    localparam int unsigned DIVIDEND_W = 33;
    localparam int unsigned PROD_W     = 34;
    localparam int unsigned TAB_W      = 17;

    typedef struct packed {
        logic signed [15:0] score;
        logic               last;
    } score_item_t;

    typedef struct packed {
        logic [3:0]  class_index;
        logic [15:0] probability;
        logic        final_result;
        logic        overflow;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_EXP1,
        ST_EXP2,
        ST_EVAL,
        ST_DIV
    } state_t;

    // exp(-k) for integer k, Q1.16
    function automatic logic [TAB_W-1:0] eint(input logic [4:0] k);
        logic [TAB_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd24109;
            5'd2:    v = 17'd8869;
            5'd3:    v = 17'd3263;
            5'd4:    v = 17'd1200;
            5'd5:    v = 17'd442;
            5'd6:    v = 17'd162;
            5'd7:    v = 17'd60;
            5'd8:    v = 17'd22;
            5'd9:    v = 17'd8;
            5'd10:   v = 17'd3;
            5'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-j/16), Q1.16
    function automatic logic [TAB_W-1:0] ehi(input logic [3:0] j);
        logic [TAB_W-1:0] v;
        case (j)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    // exp(-i/256), Q1.16
    function automatic logic [TAB_W-1:0] elo(input logic [3:0] i);
        logic [TAB_W-1:0] v;
        case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/snorm_exp.sv
// snorm_exp: two-stage exp(-m) unit, m in Q8.8, result unsigned Q0.16
// depends on snorm_pkg (exponent tables, widths)
`default_nettype none

module snorm_exp (
    input  wire logic        clk,
    input  wire logic [15:0] m,
    output logic [15:0]      e
);

    logic [snorm_pkg::PROD_W-1:0] p1_reg;
    logic [snorm_pkg::PROD_W-1:0] p1_next;
    logic [3:0]                   lo_idx_reg;
    logic                         zero1_reg;
    logic                         zero1_next;
    logic [snorm_pkg::PROD_W-1:0] p2_reg;
    logic [snorm_pkg::PROD_W-1:0] p2_next;
    logic                         zero2_reg;
    logic [snorm_pkg::PROD_W-1:0] p1_round;
    logic [snorm_pkg::TAB_W-1:0]  t;
    logic [snorm_pkg::PROD_W-1:0] p2_round;
    logic [17:0]                  e_wide;

    // stage 1: integer part times high fraction
    always_comb
    begin
        zero1_next = (m > 16'd4096);
        p1_next    = snorm_pkg::PROD_W'(snorm_pkg::eint(m[12:8]))
                   * snorm_pkg::PROD_W'(snorm_pkg::ehi(m[7:4]));
    end

    // stage 2: round, then low fraction
    always_comb
    begin
        p1_round = p1_reg + snorm_pkg::PROD_W'(32768);
        t        = p1_round[32:16];
        p2_next  = snorm_pkg::PROD_W'(t) * snorm_pkg::PROD_W'(snorm_pkg::elo(lo_idx_reg));
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        lo_idx_reg <= m[3:0];
        zero1_reg  <= zero1_next;
        p2_reg     <= p2_next;
        zero2_reg  <= zero1_reg;
    end

    always_comb
    begin
        p2_round = p2_reg + snorm_pkg::PROD_W'(32768);
        e_wide   = p2_round[33:16];
        if (zero2_reg)
        begin
            e = 16'd0;
        end
        else if (e_wide > 18'd65535)
        begin
            e = 16'hFFFF;
        end
        else
        begin
            e = e_wide[15:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/snorm_div.sv
// snorm_div: restoring divider, one quotient bit per cycle, 17-bit quotient
// depends on snorm_pkg (widths); quotient must fit 17 bits
`default_nettype none

module snorm_div #(
    parameter int unsigned SUM_W = 21
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [snorm_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [SUM_W-1:0]                    divisor,
    output logic                                     busy,
    output logic [snorm_pkg::QUOT_W-1:0]             quotient
);

    logic                         busy_reg;
    logic                         busy_next;
    logic [4:0]                   cnt_reg;
    logic [4:0]                   cnt_next;
    logic [SUM_W-1:0]             rem_reg;
    logic [SUM_W-1:0]             rem_next;
    logic [snorm_pkg::QUOT_W-1:0] quot_reg;
    logic [snorm_pkg::QUOT_W-1:0] quot_next;
    logic [SUM_W:0]               trial;
    logic [SUM_W:0]               diff;
    logic                         ge;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[snorm_pkg::QUOT_W-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(snorm_pkg::QUOT_W);
            rem_next  = SUM_W'(dividend[snorm_pkg::DIVIDEND_W-1:snorm_pkg::QUOT_W]);
            quot_next = dividend[snorm_pkg::QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quot_next = {quot_reg[snorm_pkg::QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: sv/softmax_normalizer.sv
// softmax_normalizer: fixed-point softmax with max subtraction over one score vector
// depends on snorm_pkg, snorm_exp, snorm_div
//
// Scores (signed Q8.8) are taken one per cycle while in the load state and written to an
// internal score memory while the running maximum is kept; up to MAX_CLASSES are stored
// and any further score is dropped, which sets overflow on every result of that vector.
// A transaction marked last starts two passes over the memory: a sum pass per stored
// class (memory read, two exponent multiplier stages, accumulate), then an emit pass per
// class (memory read, exponent, bit-serial divider, output register load) that also
// waits for the output register to be free. No new score is taken until the last result
// of a vector is loaded. Results leave in class order through an output register, the
// last one marked final_result, and probabilities are Q0.16 saturated at 65535.
`default_nettype none

module softmax_normalizer #(
    parameter int unsigned MAX_CLASSES = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   score_valid,
    output logic                        score_ready,
    input  wire snorm_pkg::score_item_t score_data,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output snorm_pkg::result_item_t     result_data
);

    localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
    localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int unsigned SUM_W = snorm_pkg::EXP_W + CNT_W;

    snorm_pkg::state_t       state_reg;
    snorm_pkg::state_t       state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [15:0]      max_reg;
    logic signed [15:0]      max_next;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic                    dropped_reg;
    logic                    dropped_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic                    emit_pass_reg;
    logic                    emit_pass_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    snorm_pkg::result_item_t out_data_reg;
    snorm_pkg::result_item_t out_data_next;

    logic signed [15:0]      score_mem [MAX_CLASSES];
    logic signed [15:0]      rd_data_reg;

    logic                    accept_in;
    logic                    room;
    logic                    wr_en;
    logic                    last_idx;
    logic                    out_free;
    logic [15:0]             m;
    logic [15:0]             e;
    logic                    div_start;
    logic                    div_busy;
    logic [snorm_pkg::DIVIDEND_W-1:0] dividend;
    logic [snorm_pkg::QUOT_W-1:0]     quotient;
    logic [15:0]             prob;

    assign score_ready = (state_reg == snorm_pkg::ST_LOAD);
    assign accept_in   = score_valid && score_ready;
    assign room        = (count_reg < CNT_W'(MAX_CLASSES));
    assign wr_en       = accept_in && room;
    assign last_idx    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free    = !out_valid_reg || result_ready;
    assign m           = 16'(max_reg - rd_data_reg);
    assign dividend    = {1'b0, e, 16'd0} + snorm_pkg::DIVIDEND_W'(sum_reg >> 1);

    // score memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            score_mem[count_reg[IDX_W-1:0]] <= score_data.score;
        end
        rd_data_reg <= score_mem[idx_reg];
    end

    snorm_exp u_exp (
        .clk (clk),
        .m   (m),
        .e   (e)
    );

    snorm_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        if (sum_reg == '0)
        begin
            prob = 16'd0;
        end
        else if (quotient[snorm_pkg::QUOT_W-1])
        begin
            prob = 16'hFFFF;
        end
        else
        begin
            prob = quotient[15:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            snorm_pkg::ST_LOAD:
            begin
                if (accept_in && score_data.last)
                begin
                    state_next = snorm_pkg::ST_READ;
                end
            end
            snorm_pkg::ST_READ:
            begin
                state_next = snorm_pkg::ST_EXP1;
            end
            snorm_pkg::ST_EXP1:
            begin
                state_next = snorm_pkg::ST_EXP2;
            end
            snorm_pkg::ST_EXP2:
            begin
                state_next = snorm_pkg::ST_EVAL;
            end
            snorm_pkg::ST_EVAL:
            begin
                state_next = emit_pass_reg ? snorm_pkg::ST_DIV : snorm_pkg::ST_READ;
            end
            snorm_pkg::ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    state_next = last_idx ? snorm_pkg::ST_LOAD : snorm_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = snorm_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        emit_pass_next = emit_pass_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        case (state_reg)
            snorm_pkg::ST_LOAD:
            begin
                if (accept_in)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (score_data.score > max_reg)
                        begin
                            max_next = score_data.score;
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (score_data.last)
                    begin
                        idx_next       = '0;
                        emit_pass_next = 1'b0;
                    end
                end
            end
            snorm_pkg::ST_EVAL:
            begin
                if (emit_pass_reg)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(e);
                    if (last_idx)
                    begin
                        emit_pass_next = 1'b1;
                        idx_next       = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            snorm_pkg::ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.class_index  = 4'(idx_reg);
                    out_data_next.probability  = prob;
                    out_data_next.final_result = last_idx;
                    out_data_next.overflow     = dropped_reg;
                    if (last_idx)
                    begin
                        count_next     = '0;
                        max_next       = 16'sh8000;
                        sum_next       = '0;
                        dropped_next   = 1'b0;
                        idx_next       = '0;
                        emit_pass_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snorm_pkg::ST_LOAD;
            count_reg     <= '0;
            max_reg       <= 16'sh8000;
            sum_reg       <= '0;
            dropped_reg   <= 1'b0;
            idx_reg       <= '0;
            emit_pass_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            dropped_reg   <= dropped_next;
            idx_reg       <= idx_next;
            emit_pass_reg <= emit_pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

`default_nettype wire
